@@ rtl/dcrb_pkg.sv @@
// Shared types and constants for the catch-all DNS reply builder.
// Used by every module under rtl; it has no dependencies of its own.
package dcrb_pkg;

    localparam int unsigned MaxQuestions = 4;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_LEN = 2'd0;
    localparam logic [1:0] CFG_TTL     = 2'd1;
    localparam logic [1:0] CFG_ADDR    = 2'd2;

    localparam logic [15:0] RST_MAX_LEN = 16'd512;
    localparam logic [31:0] RST_TTL     = 32'd60;
    localparam logic [31:0] RST_ADDR    = 32'hC0A8_0401;

    localparam logic [7:0] FLAGS_HI     = 8'h81;
    localparam logic [7:0] FLAGS_LO     = 8'h80;
    localparam logic [7:0] NAME_PTR_HI  = 8'hC0;
    localparam logic [7:0] NAME_PTR_LO  = 8'h0C;
    localparam logic [7:0] PTR_MASK     = 8'hC0;
    localparam logic [7:0] TYPE_A_LO    = 8'h01;
    localparam logic [7:0] RDLEN_LO     = 8'h04;
    localparam logic [7:0] TYPE_CLASS_N = 8'd4;

    localparam logic [15:0] HEADER_LEN  = 16'd12;
    localparam logic [15:0] POS_SAT     = 16'hFFFF;

    // Answer record pair indexes (eight pairs of bytes per record).
    localparam logic [2:0] ANS_NAME   = 3'd0;
    localparam logic [2:0] ANS_TYPE   = 3'd1;
    localparam logic [2:0] ANS_CLASS  = 3'd2;
    localparam logic [2:0] ANS_TTL_HI = 3'd3;
    localparam logic [2:0] ANS_TTL_LO = 3'd4;
    localparam logic [2:0] ANS_RDLEN  = 3'd5;
    localparam logic [2:0] ANS_ADR_HI = 3'd6;
    localparam logic [2:0] ANS_ADR_LO = 3'd7;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_NAME   = 3'd1,
        PH_LABEL  = 3'd2,
        PH_PTR    = 3'd3,
        PH_TYPE   = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic {
        BK_ECHO   = 1'b0,
        BK_ANSWER = 1'b1
    } t_back_state;

    // One classified request byte, passed from parser to emitter.
    typedef struct packed {
        logic [7:0] echo;
        logic       last;
        logic       drop;
        logic [2:0] qcount;
    } t_entry;

endpackage

@@ rtl/dcrb_front.sv @@
// Request parser: walks the header and question section one byte per cycle
// if there is room; needs dcrb_pkg, feeds classified bytes into dcrb_queue.
module dcrb_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_room,
    input  logic [15:0]      i_max_len,
    output logic             o_ready,
    output logic             o_push,
    output dcrb_pkg::t_entry o_entry
);

    dcrb_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_skip, n_skip;
    logic [2:0]  r_qleft, n_qleft;
    logic [2:0]  r_qtotal, n_qtotal;
    logic [7:0]  r_chigh, n_chigh;
    logic        r_bad, n_bad;

    logic        accept;
    logic [7:0]  echo;
    logic        count_ok;
    logic [16:0] total;
    logic        drop;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;

    assign count_ok = (r_chigh == 8'd0) && (i_byte != 8'd0)
                      && (i_byte <= 8'(dcrb_pkg::MaxQuestions));

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            dcrb_pkg::PH_HEADER: begin
                if (r_pos >= dcrb_pkg::HEADER_LEN - 16'd1) begin
                    n_phase = dcrb_pkg::PH_NAME;
                end
            end
            dcrb_pkg::PH_NAME: begin
                if (i_byte == 8'd0) begin
                    n_phase = dcrb_pkg::PH_TYPE;
                end else if ((i_byte & dcrb_pkg::PTR_MASK) == dcrb_pkg::PTR_MASK) begin
                    n_phase = dcrb_pkg::PH_PTR;
                end else begin
                    n_phase = dcrb_pkg::PH_LABEL;
                end
            end
            dcrb_pkg::PH_LABEL: begin
                if (r_skip <= 8'd1) begin
                    n_phase = dcrb_pkg::PH_NAME;
                end
            end
            dcrb_pkg::PH_PTR: begin
                n_phase = dcrb_pkg::PH_TYPE;
            end
            dcrb_pkg::PH_TYPE: begin
                if (r_skip <= 8'd1) begin
                    n_phase = (r_qleft <= 3'd1) ? dcrb_pkg::PH_DONE : dcrb_pkg::PH_NAME;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Datapath next values and the echoed byte.
    always_comb begin
        n_pos    = (r_pos == dcrb_pkg::POS_SAT) ? r_pos : r_pos + 16'd1;
        n_skip   = r_skip;
        n_qleft  = r_qleft;
        n_qtotal = r_qtotal;
        n_chigh  = r_chigh;
        n_bad    = r_bad || (r_pos >= i_max_len) || (r_pos == dcrb_pkg::POS_SAT);
        echo     = i_byte;
        case (r_phase)
            dcrb_pkg::PH_HEADER: begin
                if (r_pos == 16'd2) begin
                    echo = dcrb_pkg::FLAGS_HI;
                end else if (r_pos == 16'd3) begin
                    echo = dcrb_pkg::FLAGS_LO;
                end else if (r_pos == 16'd4) begin
                    n_chigh = i_byte;
                end else if (r_pos == 16'd5) begin
                    if (count_ok) begin
                        n_qtotal = i_byte[2:0];
                    end else begin
                        n_qtotal = 3'd0;
                        n_bad    = 1'b1;
                    end
                end else if (r_pos == 16'd6) begin
                    echo = r_chigh;
                end else if (r_pos == 16'd7) begin
                    echo = {5'd0, r_qtotal};
                end else if (r_pos >= 16'd8) begin
                    echo = 8'd0;
                end
                if (r_pos >= dcrb_pkg::HEADER_LEN - 16'd1) begin
                    n_qleft = r_qtotal;
                end
            end
            dcrb_pkg::PH_NAME: begin
                n_skip = (i_byte == 8'd0) ? dcrb_pkg::TYPE_CLASS_N : i_byte;
            end
            dcrb_pkg::PH_LABEL: begin
                n_skip = (r_skip <= 8'd1) ? 8'd0 : r_skip - 8'd1;
            end
            dcrb_pkg::PH_PTR: begin
                n_skip = dcrb_pkg::TYPE_CLASS_N;
            end
            dcrb_pkg::PH_TYPE: begin
                if (r_skip <= 8'd1) begin
                    n_skip  = 8'd0;
                    n_qleft = (r_qleft <= 3'd1) ? 3'd0 : r_qleft - 3'd1;
                end else begin
                    n_skip = r_skip - 8'd1;
                end
            end
            default: begin
                n_skip = r_skip;
            end
        endcase
    end

    // Reply length check: request bytes plus sixteen per answer record.
    assign total = {1'b0, n_pos} + {10'd0, n_qtotal, 4'd0};
    assign drop  = n_bad || (n_phase != dcrb_pkg::PH_DONE) || (total > {1'b0, i_max_len});

    assign o_push         = accept;
    assign o_entry.echo   = echo;
    assign o_entry.last   = i_last;
    assign o_entry.drop   = i_last && drop;
    assign o_entry.qcount = n_qtotal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_phase  <= dcrb_pkg::PH_HEADER;
            r_pos    <= 16'd0;
            r_skip   <= 8'd0;
            r_qleft  <= 3'd0;
            r_qtotal <= 3'd0;
            r_chigh  <= 8'd0;
            r_bad    <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_qleft  <= n_qleft;
            r_qtotal <= n_qtotal;
            r_chigh  <= n_chigh;
            r_bad    <= n_bad;
        end
    end

endmodule

@@ rtl/dcrb_queue.sv @@
// Short queue of classified request bytes between parser and emitter.
// Depends on dcrb_pkg for the entry type and the queue depth.
module dcrb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dcrb_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_avail,
    output dcrb_pkg::t_entry o_entry
);

    dcrb_pkg::t_entry r_mem [dcrb_pkg::QueueDepth];

    logic [dcrb_pkg::QueuePtrW-1:0] r_wr, n_wr;
    logic [dcrb_pkg::QueuePtrW-1:0] r_rd, n_rd;
    logic [dcrb_pkg::QueuePtrW:0]   r_count, n_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_room  = (r_count != (dcrb_pkg::QueuePtrW+1)'(dcrb_pkg::QueueDepth));
    assign o_avail = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    assign do_push = i_push && o_room;
    assign do_pop  = i_pop && o_avail;

    always_comb begin
        n_wr    = do_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

@@ rtl/dcrb_back.sv @@
// Reply emitter: echoes queued bytes and appends the A records after a good frame.
// Depends on dcrb_pkg; reads entries from dcrb_queue and drives the output register.
module dcrb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  dcrb_pkg::t_entry i_entry,
    output logic             o_pop,
    input  logic [31:0]      i_ttl,
    input  logic [31:0]      i_addr,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_first,
    output logic [7:0]       o_out_second,
    output logic             o_out_pair,
    output logic             o_out_last,
    output logic             o_out_drop
);

    dcrb_pkg::t_back_state r_state, n_state;
    logic [2:0] r_word, n_word;
    logic [2:0] r_qleft, n_qleft;

    logic       r_valid, n_valid;
    logic [7:0] r_first, n_first;
    logic [7:0] r_second, n_second;
    logic       r_pair, n_pair;
    logic       r_last, n_last;
    logic       r_drop, n_drop;

    logic       can_load;
    logic       good_final;
    logic       final_word;
    logic [15:0] ans_pair;

    assign can_load   = !r_valid || i_out_ready;
    assign good_final = i_entry.last && !i_entry.drop && (i_entry.qcount != 3'd0);
    assign final_word = (r_word == dcrb_pkg::ANS_ADR_LO);

    // Next state of the emitter.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcrb_pkg::BK_ECHO: begin
                if (can_load && i_avail && good_final) begin
                    n_state = dcrb_pkg::BK_ANSWER;
                end
            end
            dcrb_pkg::BK_ANSWER: begin
                if (can_load && final_word && r_qleft <= 3'd1) begin
                    n_state = dcrb_pkg::BK_ECHO;
                end
            end
            default: begin
                n_state = dcrb_pkg::BK_ECHO;
            end
        endcase
    end

    // Byte pair of the answer record at the current word.
    always_comb begin
        case (r_word)
            dcrb_pkg::ANS_NAME:   ans_pair = {dcrb_pkg::NAME_PTR_HI, dcrb_pkg::NAME_PTR_LO};
            dcrb_pkg::ANS_TYPE:   ans_pair = {8'd0, dcrb_pkg::TYPE_A_LO};
            dcrb_pkg::ANS_CLASS:  ans_pair = {8'd0, dcrb_pkg::TYPE_A_LO};
            dcrb_pkg::ANS_TTL_HI: ans_pair = i_ttl[31:16];
            dcrb_pkg::ANS_TTL_LO: ans_pair = i_ttl[15:0];
            dcrb_pkg::ANS_RDLEN:  ans_pair = {8'd0, dcrb_pkg::RDLEN_LO};
            dcrb_pkg::ANS_ADR_HI: ans_pair = i_addr[31:16];
            dcrb_pkg::ANS_ADR_LO: ans_pair = i_addr[15:0];
            default:              ans_pair = 16'd0;
        endcase
    end

    // Output register loading and counters.
    always_comb begin
        o_pop    = 1'b0;
        n_word   = r_word;
        n_qleft  = r_qleft;
        n_valid  = r_valid && !i_out_ready;
        n_first  = r_first;
        n_second = r_second;
        n_pair   = r_pair;
        n_last   = r_last;
        n_drop   = r_drop;
        case (r_state)
            dcrb_pkg::BK_ECHO: begin
                if (can_load && i_avail) begin
                    o_pop    = 1'b1;
                    n_valid  = 1'b1;
                    n_first  = i_entry.echo;
                    n_second = 8'd0;
                    n_pair   = 1'b0;
                    n_last   = i_entry.last && !good_final;
                    n_drop   = i_entry.drop;
                    n_word   = dcrb_pkg::ANS_NAME;
                    n_qleft  = i_entry.qcount;
                end
            end
            dcrb_pkg::BK_ANSWER: begin
                if (can_load) begin
                    n_valid  = 1'b1;
                    n_first  = ans_pair[15:8];
                    n_second = ans_pair[7:0];
                    n_pair   = 1'b1;
                    n_last   = final_word && (r_qleft <= 3'd1);
                    n_drop   = 1'b0;
                    n_word   = r_word + 3'd1;
                    if (final_word) begin
                        n_qleft = r_qleft - 3'd1;
                    end
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcrb_pkg::BK_ECHO;
            r_valid <= 1'b0;
            r_word  <= 3'd0;
            r_qleft <= 3'd0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_word  <= n_word;
            r_qleft <= n_qleft;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_second <= n_second;
        r_pair   <= n_pair;
        r_last   <= n_last;
        r_drop   <= n_drop;
    end

    assign o_out_valid  = r_valid;
    assign o_out_first  = r_first;
    assign o_out_second = r_second;
    assign o_out_pair   = r_pair;
    assign o_out_last   = r_last;
    assign o_out_drop   = r_drop;

endmodule

@@ rtl/dns_catchall_reply_builder.sv @@
// Top level of the catch-all DNS reply builder: configuration registers,
// parser, queue and emitter. Depends on dcrb_pkg, dcrb_front, dcrb_queue, dcrb_back.
//
//   channel  direction  handshake                    payload
//   in       input      i_in_valid / o_in_ready      i_in_byte, i_in_last
//   out      output     o_out_valid / i_out_ready    o_out_first, o_out_second,
//                                                    o_out_pair, o_out_last, o_out_drop
//   cfg      input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Each request byte is parsed combinationally, queued and then loaded into the
// output register; the emitter delivers one result per cycle while i_out_ready
// is high, so a good final byte is followed by eight answer pairs per question.
// A four-entry queue sits between parser and emitter; the input stalls only when
// it is full. Reset is synchronous and clears the parse state, the queue and the
// output valid flag, and loads the configuration defaults.
module dns_catchall_reply_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_first,
    output logic [7:0]  o_out_second,
    output logic        o_out_pair,
    output logic        o_out_last,
    output logic        o_out_drop,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [15:0] r_max_len;
    logic [31:0] r_ttl;
    logic [31:0] r_addr;

    logic             push;
    logic             pop;
    logic             room;
    logic             avail;
    dcrb_pkg::t_entry front_entry;
    dcrb_pkg::t_entry queue_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= dcrb_pkg::RST_MAX_LEN;
            r_ttl     <= dcrb_pkg::RST_TTL;
            r_addr    <= dcrb_pkg::RST_ADDR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dcrb_pkg::CFG_MAX_LEN: r_max_len <= i_cfg_data[15:0];
                dcrb_pkg::CFG_TTL:     r_ttl     <= i_cfg_data;
                dcrb_pkg::CFG_ADDR:    r_addr    <= i_cfg_data;
                default:               r_addr    <= r_addr;
            endcase
        end
    end

    dcrb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_byte    (i_in_byte),
        .i_last    (i_in_last),
        .i_room    (room),
        .i_max_len (r_max_len),
        .o_ready   (o_in_ready),
        .o_push    (push),
        .o_entry   (front_entry)
    );

    dcrb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_room  (room),
        .o_avail (avail),
        .o_entry (queue_entry)
    );

    dcrb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (avail),
        .i_entry      (queue_entry),
        .o_pop        (pop),
        .i_ttl        (r_ttl),
        .i_addr       (r_addr),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_out_first  (o_out_first),
        .o_out_second (o_out_second),
        .o_out_pair   (o_out_pair),
        .o_out_last   (o_out_last),
        .o_out_drop   (o_out_drop)
    );

endmodule

@@ tb/dns_catchall_reply_builder_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for dns_catchall_reply_builder: streams DNS queries in,
// predicts every echoed byte and answer record, and checks the reply stream in order.
// Depends on dcrb_pkg and the RTL under rtl.
module dns_catchall_reply_builder_tb;

    localparam int GapMax      = 4;
    localparam int StallMax    = 15;
    localparam int RandomItems = 60;
    localparam logic [1:0] CfgUnused = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_query_byte;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic       pair;
        logic       last;
        logic       drop;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte    = 8'd0;
    logic        i_in_last    = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [7:0]  o_out_first;
    logic [7:0]  o_out_second;
    logic        o_out_pair;
    logic        o_out_last;
    logic        o_out_drop;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index  = 2'd0;
    logic [31:0] i_cfg_data   = 32'd0;

    dns_catchall_reply_builder u_top (.*);

    // Mirror of the configuration registers.
    logic [15:0] max_len_cfg = dcrb_pkg::RST_MAX_LEN;
    logic [31:0] ttl_cfg     = dcrb_pkg::RST_TTL;
    logic [31:0] addr_cfg    = dcrb_pkg::RST_ADDR;

    // Mirror of the parse state of the current request.
    logic [15:0]      seen_len      = 16'd0;
    dcrb_pkg::t_phase walk_phase    = dcrb_pkg::PH_HEADER;
    logic [7:0]       bytes_to_skip = 8'd0;
    logic [2:0]       qd_left       = 3'd0;
    logic [2:0]       qd_total      = 3'd0;
    logic [7:0]       qdcount_hi    = 8'd0;
    logic             reject        = 1'b0;

    t_query_byte query_q[$];
    t_reply      reply_q[$];
    logic [7:0]  frame_buf[$];

    int          err_cnt     = 0;
    int          items_sent  = 0;
    longint      cycle_cnt   = 0;
    longint      cycle_limit = 20000;

    // Sender and receiver pacing.
    bit          gap_on      = 1'b1;
    bit          stall_on    = 1'b1;
    int          gap_left    = 0;
    int          burst_left  = 0;
    bit          in_taken    = 1'b0;
    t_query_byte next_req;
    logic [15:0] stall_pat   = 16'hFFFF;
    int          pat_left    = 64;
    t_reply      want;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    task automatic clear_walk();
        seen_len      = 16'd0;
        walk_phase    = dcrb_pkg::PH_HEADER;
        bytes_to_skip = 8'd0;
        qd_left       = 3'd0;
        qd_total      = 3'd0;
        qdcount_hi    = 8'd0;
        reject        = 1'b0;
    endtask

    task automatic push_reply(input logic [7:0] first, input logic [7:0] second,
                              input logic pair, input logic last, input logic drop);
        t_reply r;
        r.first  = first;
        r.second = second;
        r.pair   = pair;
        r.last   = last;
        r.drop   = drop;
        reply_q.push_back(r);
    endtask

    // Works out the reply items caused by one accepted request byte.
    task automatic predict_reply(input logic [7:0] b, input logic last);
        logic [15:0] pos;
        logic [7:0]  echo;
        int unsigned total;
        logic        fin;
        pos  = seen_len;
        echo = b;
        if (pos >= max_len_cfg || pos == dcrb_pkg::POS_SAT) reject = 1'b1;
        if (pos != dcrb_pkg::POS_SAT) seen_len = pos + 16'd1;
        case (walk_phase)
            dcrb_pkg::PH_HEADER: begin
                if (pos == 16'd2) echo = dcrb_pkg::FLAGS_HI;
                else if (pos == 16'd3) echo = dcrb_pkg::FLAGS_LO;
                else if (pos == 16'd4) qdcount_hi = b;
                else if (pos == 16'd5) begin
                    if (qdcount_hi == 8'd0 && b >= 8'd1 && b <= dcrb_pkg::MaxQuestions) begin
                        qd_total = b[2:0];
                    end else begin
                        qd_total = 3'd0;
                        reject   = 1'b1;
                    end
                end else if (pos == 16'd6) echo = qdcount_hi;
                else if (pos == 16'd7) echo = {5'd0, qd_total};
                else if (pos >= 16'd8) echo = 8'd0;
                if (pos >= dcrb_pkg::HEADER_LEN - 16'd1) begin
                    qd_left    = qd_total;
                    walk_phase = dcrb_pkg::PH_NAME;
                end
            end
            dcrb_pkg::PH_NAME: begin
                if (b == 8'd0) begin
                    bytes_to_skip = dcrb_pkg::TYPE_CLASS_N;
                    walk_phase    = dcrb_pkg::PH_TYPE;
                end else if ((b & dcrb_pkg::PTR_MASK) == dcrb_pkg::PTR_MASK) begin
                    walk_phase = dcrb_pkg::PH_PTR;
                end else begin
                    bytes_to_skip = b;
                    walk_phase    = dcrb_pkg::PH_LABEL;
                end
            end
            dcrb_pkg::PH_LABEL: begin
                if (bytes_to_skip <= 8'd1) begin
                    bytes_to_skip = 8'd0;
                    walk_phase    = dcrb_pkg::PH_NAME;
                end else begin
                    bytes_to_skip--;
                end
            end
            dcrb_pkg::PH_PTR: begin
                bytes_to_skip = dcrb_pkg::TYPE_CLASS_N;
                walk_phase    = dcrb_pkg::PH_TYPE;
            end
            dcrb_pkg::PH_TYPE: begin
                if (bytes_to_skip <= 8'd1) begin
                    bytes_to_skip = 8'd0;
                    if (qd_left <= 3'd1) begin
                        qd_left    = 3'd0;
                        walk_phase = dcrb_pkg::PH_DONE;
                    end else begin
                        qd_left--;
                        walk_phase = dcrb_pkg::PH_NAME;
                    end
                end else begin
                    bytes_to_skip--;
                end
            end
            default: begin
            end
        endcase

        if (!last) begin
            push_reply(echo, 8'd0, 1'b0, 1'b0, 1'b0);
        end else begin
            total = seen_len + 16 * qd_total;
            if (reject || walk_phase != dcrb_pkg::PH_DONE || total > max_len_cfg) begin
                push_reply(echo, 8'd0, 1'b0, 1'b1, 1'b1);
            end else begin
                push_reply(echo, 8'd0, 1'b0, 1'b0, 1'b0);
                for (int q = 0; q < qd_total; q++) begin
                    fin = (q + 1 == qd_total);
                    push_reply(dcrb_pkg::NAME_PTR_HI, dcrb_pkg::NAME_PTR_LO,
                               1'b1, 1'b0, 1'b0);
                    push_reply(8'h00, dcrb_pkg::TYPE_A_LO, 1'b1, 1'b0, 1'b0);
                    push_reply(8'h00, dcrb_pkg::TYPE_A_LO, 1'b1, 1'b0, 1'b0);
                    push_reply(ttl_cfg[31:24], ttl_cfg[23:16], 1'b1, 1'b0, 1'b0);
                    push_reply(ttl_cfg[15:8], ttl_cfg[7:0], 1'b1, 1'b0, 1'b0);
                    push_reply(8'h00, dcrb_pkg::RDLEN_LO, 1'b1, 1'b0, 1'b0);
                    push_reply(addr_cfg[31:24], addr_cfg[23:16], 1'b1, 1'b0, 1'b0);
                    push_reply(addr_cfg[15:8], addr_cfg[7:0], 1'b1, fin, 1'b0);
                end
            end
            clear_walk();
        end
    endtask

    // Request acceptance feeds the predictor; reply acceptance is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_reply(i_in_byte, i_in_last);
            in_taken = 1'b1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reply_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected reply %h %h pair %0b last %0b drop %0b",
                         $time, o_out_first, o_out_second, o_out_pair, o_out_last,
                         o_out_drop);
            end else begin
                want = reply_q.pop_front();
                if (o_out_first !== want.first || o_out_second !== want.second ||
                    o_out_pair !== want.pair || o_out_last !== want.last ||
                    o_out_drop !== want.drop) begin
                    err_cnt++;
                    $display("%0t: expected %h %h %0b%0b%0b, got %h %h %0b%0b%0b %s",
                             $time, want.first, want.second, want.pair, want.last,
                             want.drop, o_out_first, o_out_second, o_out_pair,
                             o_out_last, o_out_drop, "(pair last drop)");
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > cycle_limit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (query_q.size() != 0) begin
                next_req = query_q.pop_front();
                i_in_byte  <= next_req.data;
                i_in_last  <= next_req.last;
                i_in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 32);
                    gap_left   = gap_on ? $urandom_range(0, GapMax) : 0;
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
            in_taken = 1'b0;
        end
    end

    // Receiver: a rotating stall pattern, reloaded now and then.  Bit 0 is forced
    // high so that every reloaded pattern holds at least one ready bit.
    always @(negedge i_clk) begin
        if (stall_on) begin
            i_out_ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            pat_left--;
            if (pat_left == 0) begin
                stall_pat = 16'($urandom) | 16'd1;
                pat_left  = 64;
            end
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            dcrb_pkg::CFG_MAX_LEN: max_len_cfg = data[15:0];
            dcrb_pkg::CFG_TTL:     ttl_cfg = data;
            dcrb_pkg::CFG_ADDR:    addr_cfg = data;
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_max_len(input logic [15:0] len);
        logic [15:0] junk;
        junk = 16'($urandom);
        write_reg(dcrb_pkg::CFG_MAX_LEN, {junk, len});
    endtask

    // Waits until every request has gone in and every reply has come out.
    task automatic wait_idle();
        while (query_q.size() != 0 || i_in_valid || reply_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic add_header(input logic [7:0] cnt_hi, input logic [7:0] cnt_lo);
        repeat (4) frame_buf.push_back(8'($urandom));
        frame_buf.push_back(cnt_hi);
        frame_buf.push_back(cnt_lo);
        repeat (6) frame_buf.push_back(8'($urandom));
    endtask

    // One question: labels, then a zero byte or a pointer, then type and class.
    task automatic add_name(input int n_labels, input int first_len, input bit use_ptr);
        int len;
        for (int l = 0; l < n_labels; l++) begin
            len = (l == 0 && first_len > 0) ? first_len : $urandom_range(1, 12);
            frame_buf.push_back(8'(len));
            repeat (len) frame_buf.push_back(8'($urandom));
        end
        if (use_ptr) begin
            frame_buf.push_back(dcrb_pkg::PTR_MASK | 8'($urandom_range(0, 63)));
            frame_buf.push_back(8'($urandom));
        end else begin
            frame_buf.push_back(8'h00);
        end
        repeat (dcrb_pkg::TYPE_CLASS_N) frame_buf.push_back(8'($urandom));
    endtask

    task automatic add_random_name();
        add_name($urandom_range(0, 3),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(64, 191) : 0,
                 $urandom_range(0, 2) == 0);
    endtask

    // kind below 65 gives a well-formed query; the rest are cut short, carry a
    // bad question count, are shorter than a header, or are pure noise.
    task automatic build_frame(input int kind);
        int nq;
        int keep;
        nq = $urandom_range(1, dcrb_pkg::MaxQuestions);
        if (kind < 90) begin
            if (kind < 75) begin
                add_header(8'd0, 8'(nq));
            end else if (kind < 82) begin
                add_header(8'($urandom_range(1, 255)), 8'($urandom));
            end else begin
                add_header(8'd0, $urandom_range(0, 1) ? 8'd0
                           : 8'($urandom_range(dcrb_pkg::MaxQuestions + 1, 255)));
            end
            repeat (nq) add_random_name();
            repeat ($urandom_range(0, 2)) frame_buf.push_back(8'($urandom));
            if (kind >= 65 && kind < 75) begin
                keep = $urandom_range(dcrb_pkg::HEADER_LEN, frame_buf.size() - 1);
                while (frame_buf.size() > keep) void'(frame_buf.pop_back());
            end
        end else if (kind < 94) begin
            repeat ($urandom_range(1, dcrb_pkg::HEADER_LEN - 1))
                frame_buf.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(dcrb_pkg::HEADER_LEN, 40))
                frame_buf.push_back(8'($urandom));
        end
    endtask

    task automatic send_frame();
        t_query_byte qb;
        for (int i = 0; i < frame_buf.size(); i++) begin
            qb.data = frame_buf[i];
            qb.last = (i == frame_buf.size() - 1);
            query_q.push_back(qb);
        end
        items_sent += frame_buf.size();
        cycle_limit += 4 * frame_buf.size() * (GapMax + StallMax + 3)
                     + 4 * (32 * (StallMax + 1) + 100);
        frame_buf.delete();
    endtask

    initial begin
        int need;
        int start_items;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: root name, pointers, a long label, short and bad frames.
        add_header(8'd0, 8'd1);
        add_name(0, 0, 1'b0);
        send_frame();
        add_header(8'd0, 8'(dcrb_pkg::MaxQuestions));
        repeat (dcrb_pkg::MaxQuestions) add_name(0, 0, 1'b1);
        send_frame();
        add_header(8'd0, 8'd1);
        add_name(1, 8'h40, 1'b1);
        frame_buf.push_back(8'($urandom));
        send_frame();
        frame_buf.push_back(8'($urandom));
        send_frame();
        repeat (dcrb_pkg::HEADER_LEN - 1) frame_buf.push_back(8'($urandom));
        send_frame();
        add_header(8'd0, 8'd1);
        send_frame();
        add_header(8'd0, 8'd0);
        add_name(0, 0, 1'b0);
        send_frame();
        add_header(8'd0, 8'(dcrb_pkg::MaxQuestions + 1));
        add_name(0, 0, 1'b1);
        send_frame();
        add_header(8'd1, 8'd1);
        add_name(0, 0, 1'b0);
        send_frame();
        wait_idle();

        // A length limit of one header length drops everything; zero TTL and address.
        set_max_len(dcrb_pkg::HEADER_LEN);
        write_reg(dcrb_pkg::CFG_TTL, 32'd0);
        write_reg(dcrb_pkg::CFG_ADDR, 32'd0);
        write_reg(CfgUnused, $urandom);
        add_header(8'd0, 8'd1);
        add_name(0, 0, 1'b0);
        send_frame();
        add_header(8'd0, 8'd1);
        send_frame();
        wait_idle();

        // Largest settings.
        set_max_len(16'hFFFF);
        write_reg(dcrb_pkg::CFG_TTL, 32'hFFFF_FFFF);
        write_reg(dcrb_pkg::CFG_ADDR, 32'hFFFF_FFFF);
        add_header(8'd0, 8'(dcrb_pkg::MaxQuestions));
        repeat (dcrb_pkg::MaxQuestions) add_name(0, 0, 1'b1);
        send_frame();
        wait_idle();

        // Request plus answers exactly at the limit, then one byte over it.
        add_header(8'd0, 8'd1);
        add_name(0, 0, 1'b0);
        need = frame_buf.size() + 16 * frame_buf[5];
        set_max_len(16'(need));
        send_frame();
        wait_idle();
        add_header(8'd0, 8'd1);
        add_name(0, 0, 1'b0);
        need = frame_buf.size() + 16 * frame_buf[5];
        set_max_len(16'(need - 1));
        send_frame();
        wait_idle();

        start_items = items_sent;
        while (items_sent - start_items < RandomItems) begin
            wait_idle();
            if ($urandom_range(0, 1))
                set_max_len(($urandom_range(0, 3) == 0)
                            ? 16'($urandom_range(dcrb_pkg::HEADER_LEN, 65535))
                            : 16'($urandom_range(40, 400)));
            if ($urandom_range(0, 1)) write_reg(dcrb_pkg::CFG_TTL, $urandom);
            if ($urandom_range(0, 1)) write_reg(dcrb_pkg::CFG_ADDR, $urandom);
            gap_on   = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 2)) begin
                build_frame($urandom_range(0, 99));
                send_frame();
            end
        end

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
